/* sv/dat_subcode_timecode_generator_macros.svh */
// Assertion macros for the DAT subcode timecode generator
`ifndef DAT_SUBCODE_TIMECODE_GENERATOR_MACROS_SVH
`define DAT_SUBCODE_TIMECODE_GENERATOR_MACROS_SVH

// clocked check, off while reset is asserted
`define DSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define DSG_ASSERT_IMP(label, ante, cons, msg) \
  `DSG_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* sv/dsg_pkg.sv */
// Types, constants and helper functions for the DAT subcode timecode generator
package dsg_pkg;

  typedef enum logic [1:0] {
    RATE_48K = 2'd0,
    RATE_44K = 2'd1,
    RATE_32K = 2'd2
  } dsg_rate_t;

  // second within the 3 s block
  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } dsg_phase_t;

  // BCD time kept by a counter, one set per play mode
  typedef struct packed {
    dsg_phase_t  phase;
    logic [3:0]  hr_t;
    logic [3:0]  hr_u;
    logic [2:0]  mn_t;
    logic [3:0]  mn_u;
    logic [2:0]  sc_t;
    logic [3:0]  sc_u;
    logic [1:0]  fr_t;
    logic [3:0]  fr_u;
  } dsg_clock_t;

  // BCD bytes of one time
  typedef struct packed {
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] frames;
  } dsg_time_t;

  // decimal digits of the program number
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } dsg_digits_t;

  localparam logic [3:0] ITEM_REL   = 4'd1;
  localparam logic [3:0] ITEM_ABS   = 4'd2;
  localparam logic [7:0] SID_PVALID = 8'h80;
  localparam logic [7:0] SID_START  = 8'h40;
  localparam logic [7:0] PNO_FLAG   = 8'h01;
  localparam logic [7:0] MID_LP     = 8'h40;

  // last frame number of a second, BCD
  localparam logic [1:0] SP_LAST_T  = 2'd3;
  localparam logic [3:0] SP_LAST_U  = 4'd2;
  localparam logic [3:0] SP_LONG_U  = 4'd3;
  localparam logic [1:0] LP_LAST_T  = 2'd1;
  localparam logic [3:0] LP_LAST_U  = 4'd6;
  localparam logic [3:0] LP_SHORT_U = 4'd5;

  function automatic logic [7:0] dsg_xor7(logic [55:0] b);
    return b[55:48] ^ b[47:40] ^ b[39:32] ^ b[31:24] ^ b[23:16] ^ b[15:8] ^ b[7:0];
  endfunction

  function automatic logic [7:0] dsg_xor3(logic [23:0] b);
    return b[23:16] ^ b[15:8] ^ b[7:0];
  endfunction

  // reciprocal multiply: exact over the whole 10-bit range
  function automatic dsg_digits_t dsg_pno_digits(logic [9:0] pno);
    dsg_digits_t d;
    logic [15:0] p100;
    logic [9:0]  r10;
    logic [6:0]  r;
    logic [14:0] p10;
    logic [7:0]  t10;
    p100    = {6'd0, pno} * 16'd41;
    d.hund  = p100[15:12];
    r10     = pno - (10'(d.hund) * 10'd100);
    r       = r10[6:0];
    p10     = {8'd0, r} * 15'd205;
    d.tens  = p10[14:11];
    t10     = {4'd0, d.tens} * 8'd10;
    d.units = r[3:0] - t10[3:0];
    return d;
  endfunction

  // one frame step of a BCD time
  function automatic dsg_clock_t dsg_tick(dsg_clock_t c, logic lp);
    dsg_clock_t n;
    logic [1:0] last_t;
    logic [3:0] last_u;
    n = c;
    if (lp) begin
      last_t = LP_LAST_T;
      last_u = (c.phase == PH_C) ? LP_SHORT_U : LP_LAST_U;
    end else begin
      last_t = SP_LAST_T;
      last_u = (c.phase == PH_C) ? SP_LONG_U : SP_LAST_U;
    end
    if (c.fr_t == last_t && c.fr_u == last_u) begin
      n.fr_t = '0;
      n.fr_u = '0;
      case (c.phase)
        PH_A:    n.phase = PH_B;
        PH_B:    n.phase = PH_C;
        default: n.phase = PH_A;
      endcase
      if (c.sc_u != 4'd9) begin
        n.sc_u = c.sc_u + 4'd1;
      end else begin
        n.sc_u = '0;
        if (c.sc_t != 3'd5) begin
          n.sc_t = c.sc_t + 3'd1;
        end else begin
          n.sc_t = '0;
          if (c.mn_u != 4'd9) begin
            n.mn_u = c.mn_u + 4'd1;
          end else begin
            n.mn_u = '0;
            if (c.mn_t != 3'd5) begin
              n.mn_t = c.mn_t + 3'd1;
            end else begin
              n.mn_t = '0;
              if (c.hr_u != 4'd9) begin
                n.hr_u = c.hr_u + 4'd1;
              end else begin
                n.hr_u = '0;
                n.hr_t = (c.hr_t == 4'd9) ? 4'd0 : c.hr_t + 4'd1;
              end
            end
          end
        end
      end
    end else if (c.fr_u == 4'd9) begin
      n.fr_u = '0;
      n.fr_t = c.fr_t + 2'd1;
    end else begin
      n.fr_u = c.fr_u + 4'd1;
    end
    return n;
  endfunction

endpackage

/* sv/dsg_in_if.sv */
// Frame request channel: valid/ready plus frame control fields
interface dsg_in_if;
  logic       valid;
  logic       ready;
  logic       restart_relative;
  logic [1:0] rate_code;
  logic [9:0] track_no;
  logic       start_mark;

  modport source (output valid, restart_relative, rate_code, track_no, start_mark,
                  input ready);
  modport sink (input valid, restart_relative, rate_code, track_no, start_mark,
                output ready);
endinterface

/* sv/dsg_out_if.sv */
// Subcode result channel: valid/ready plus packs and ID words
interface dsg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] relative_pack;
  logic [63:0] absolute_pack;
  logic [31:0] sub_id_word;
  logic [31:0] main_id_word;

  modport source (output valid, relative_pack, absolute_pack, sub_id_word, main_id_word,
                  input ready);
  modport sink (input valid, relative_pack, absolute_pack, sub_id_word, main_id_word,
                output ready);
endinterface

/* sv/dsg_time_ctr.sv */
// Frame counter with running BCD time for standard and long play
module dsg_time_ctr #(
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              clr,
  input  logic              long_play,
  output dsg_pkg::dsg_time_t tm
);
  import dsg_pkg::*;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_cur;
  dsg_clock_t sp_r, sp_nxt, sp_cur;
  dsg_clock_t lp_r, lp_nxt, lp_cur;
  dsg_clock_t sel;

  always_comb begin
    cnt_cur = clr ? '0 : cnt_r;
    sp_cur  = clr ? '0 : sp_r;
    lp_cur  = clr ? '0 : lp_r;
    cnt_nxt = cnt_r;
    sp_nxt  = sp_r;
    lp_nxt  = lp_r;
    if (adv) begin
      if (&cnt_cur) begin
        // counter wraps, time restarts at zero
        cnt_nxt = '0;
        sp_nxt  = '0;
        lp_nxt  = '0;
      end else begin
        cnt_nxt = cnt_cur + COUNT_BITS'(1);
        sp_nxt  = dsg_tick(sp_cur, 1'b0);
        lp_nxt  = dsg_tick(lp_cur, 1'b1);
      end
    end
  end

  always_comb begin
    sel        = long_play ? lp_cur : sp_cur;
    tm.hours   = {sel.hr_t, sel.hr_u};
    tm.minutes = {1'b0, sel.mn_t, sel.mn_u};
    tm.seconds = {1'b0, sel.sc_t, sel.sc_u};
    tm.frames  = {2'b00, sel.fr_t, sel.fr_u};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sp_r  <= '0;
      lp_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sp_r  <= sp_nxt;
      lp_r  <= lp_nxt;
    end
  end
endmodule

/* sv/dsg_pack_fmt.sv */
// Builds one 8-byte time pack with item code, program number and parity
module dsg_pack_fmt (
  input  logic [3:0]           item,
  input  dsg_pkg::dsg_digits_t dig,
  input  logic                 pno_nz,
  input  dsg_pkg::dsg_time_t   tm,
  output logic [63:0]          pack
);
  import dsg_pkg::*;

  logic [7:0]  b0, b1, b2;
  logic [55:0] body;

  always_comb begin
    b0   = {item, dig.hund};
    b1   = pno_nz ? {dig.tens, dig.units} : 8'h00;
    b2   = pno_nz ? PNO_FLAG : 8'h00;
    body = {b0, b1, b2, tm.hours, tm.minutes, tm.seconds, tm.frames};
    pack = {body, dsg_xor7(body)};
  end
endmodule

/* sv/dat_subcode_timecode_generator.sv */
// Top level: DAT subcode pack and ID word generator
// The result is registered: result valid rises in the cycle after the frame transfer.
// Throughput: one frame per cycle while the result side is ready; the frame counters carry
// BCD time, so each frame only formats registered state into the result register.
// Reset: both frame counters, the long-play register and result valid clear.
`include "dat_subcode_timecode_generator_macros.svh"

module dat_subcode_timecode_generator #(
  parameter int COUNT_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  dsg_in_if.sink    in_chan,
  dsg_out_if.source out_chan
);
  import dsg_pkg::*;

  logic        fire;
  logic        long_play_r, long_play_nxt;
  logic        out_valid_r, out_valid_nxt;
  dsg_time_t   rel_tm, abs_tm;
  dsg_digits_t dig;
  logic        pno_nz;
  logic [63:0] rel_pack_nxt, abs_pack_nxt, rel_pack_r, abs_pack_r;
  logic [31:0] sub_nxt, main_nxt, sub_r, main_r;
  logic [7:0]  s0, s1, s2, m0, m1;
  logic [1:0]  rbits;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  dsg_time_ctr #(.COUNT_BITS(COUNT_BITS)) u_rel_ctr (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (fire),
    .clr       (in_chan.restart_relative),
    .long_play (long_play_r),
    .tm        (rel_tm)
  );

  dsg_time_ctr #(.COUNT_BITS(COUNT_BITS)) u_abs_ctr (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (fire),
    .clr       (1'b0),
    .long_play (long_play_r),
    .tm        (abs_tm)
  );

  assign dig    = dsg_pno_digits(in_chan.track_no);
  assign pno_nz = (in_chan.track_no != 10'd0);

  dsg_pack_fmt u_rel_fmt (
    .item   (ITEM_REL),
    .dig    (dig),
    .pno_nz (pno_nz),
    .tm     (rel_tm),
    .pack   (rel_pack_nxt)
  );

  dsg_pack_fmt u_abs_fmt (
    .item   (ITEM_ABS),
    .dig    (dig),
    .pno_nz (pno_nz),
    .tm     (abs_tm),
    .pack   (abs_pack_nxt)
  );

  always_comb begin
    unique case (dsg_rate_t'(in_chan.rate_code))
      RATE_44K: rbits = 2'd1;
      RATE_32K: rbits = 2'd2;
      default:  rbits = 2'd0;
    endcase
    s0       = (pno_nz ? SID_PVALID : 8'h00) | (in_chan.start_mark ? SID_START : 8'h00);
    s1       = pno_nz ? PNO_FLAG : 8'h00;
    s2       = pno_nz ? {dig.tens, dig.units} : 8'h00;
    sub_nxt  = {s0, s1, s2, dsg_xor3({s0, s1, s2})};
    m0       = {4'd0, rbits, 2'd0};
    m1       = long_play_r ? MID_LP : 8'h00;
    main_nxt = {m0, m1, 8'h00, dsg_xor3({m0, m1, 8'h00})};
  end

  always_comb begin
    long_play_nxt = cfg_we ? cfg_wdata : long_play_r;
    out_valid_nxt = fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_play_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      long_play_r <= long_play_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rel_pack_r <= rel_pack_nxt;
      abs_pack_r <= abs_pack_nxt;
      sub_r      <= sub_nxt;
      main_r     <= main_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.relative_pack = rel_pack_r;
  assign out_chan.absolute_pack = abs_pack_r;
  assign out_chan.sub_id_word   = sub_r;
  assign out_chan.main_id_word  = main_r;

  `DSG_ASSERT_IMP(a_rel_parity, out_valid_r, dsg_xor7(rel_pack_r[63:8]) == rel_pack_r[7:0], "relative pack parity mismatch")
  `DSG_ASSERT_IMP(a_abs_parity, out_valid_r, dsg_xor7(abs_pack_r[63:8]) == abs_pack_r[7:0], "absolute pack parity mismatch")
  `DSG_ASSERT_IMP(a_id_parity, out_valid_r, (dsg_xor3(sub_r[31:8]) == sub_r[7:0]) && (dsg_xor3(main_r[31:8]) == main_r[7:0]), "ID word parity mismatch")
  `DSG_ASSERT(a_restart_zero, (fire && in_chan.restart_relative) |=> (rel_pack_r[39:8] == 32'd0), "relative time not zero after restart")

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the DAT subcode timecode generator with a scoreboard class
module tb;
  import dsg_pkg::*;

  localparam logic [1:0] RATE_NONE = 2'd3;

  typedef struct packed {
    logic [63:0] relative_pack;
    logic [63:0] absolute_pack;
    logic [31:0] sub_id_word;
    logic [31:0] main_id_word;
  } subcode_t;

  class subcode_scoreboard;
    logic [23:0] abs_frames;
    logic [23:0] rel_frames;
    bit          long_play;
    subcode_t    expected_subcode[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      abs_frames   = '0;
      rel_frames   = '0;
      long_play    = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function logic [7:0] to_bcd(int unsigned v);
      return {4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    // time pack for frame count n under the current play mode
    function logic [63:0] time_pack(logic [3:0] item, logic [9:0] pno, logic [23:0] n);
      int unsigned per_block, first, second, rest, secs, fr, p;
      logic [7:0]  b [0:7];
      per_block = long_play ? 50 : 100;
      first     = long_play ? 17 : 33;
      second    = long_play ? 34 : 66;
      p         = pno;
      rest      = n % per_block;
      secs      = (n / per_block) * 3;
      if (rest < first) begin
        fr = rest;
      end else if (rest < second) begin
        secs += 1;
        fr = rest - first;
      end else begin
        secs += 2;
        fr = rest - second;
      end
      b[0] = {item, 4'(p / 100)};
      b[1] = (p == 0) ? 8'h00 : to_bcd(p);
      b[2] = (p == 0) ? 8'h00 : PNO_FLAG;
      b[3] = to_bcd(secs / 3600);
      b[4] = to_bcd((secs / 60) % 60);
      b[5] = to_bcd(secs % 60);
      b[6] = to_bcd(fr);
      b[7] = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
      return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    endfunction

    function logic [31:0] id_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      return {b0, b1, b2, b0 ^ b1 ^ b2};
    endfunction

    function void note_frame(logic restart, logic [1:0] rate, logic [9:0] pno, logic smark);
      subcode_t   s;
      logic [1:0] rate_bits;
      if (restart) rel_frames = '0;
      s.relative_pack = time_pack(ITEM_REL, pno, rel_frames);
      s.absolute_pack = time_pack(ITEM_ABS, pno, abs_frames);
      s.sub_id_word = id_word((pno != 0 ? SID_PVALID : 8'h00) | (smark ? SID_START : 8'h00),
                              pno != 0 ? PNO_FLAG : 8'h00,
                              pno != 0 ? to_bcd(pno) : 8'h00);
      rate_bits = (rate == RATE_44K || rate == RATE_32K) ? rate : 2'd0;
      s.main_id_word = id_word({4'd0, rate_bits, 2'd0}, long_play ? MID_LP : 8'h00, 8'h00);
      expected_subcode.push_back(s);
      abs_frames = abs_frames + 24'd1;
      rel_frames = rel_frames + 24'd1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want)
        flag($sformatf("result %0d %s: expected %h, got %h", results_seen, name, want, got));
    endfunction

    function void check_subcode(subcode_t got);
      subcode_t want;
      results_seen++;
      if (expected_subcode.size() == 0) begin
        flag($sformatf("result %0d arrived with no frame pending", results_seen));
        return;
      end
      want = expected_subcode.pop_front();
      compare_field("relative_pack", want.relative_pack, got.relative_pack);
      compare_field("absolute_pack", want.absolute_pack, got.absolute_pack);
      compare_field("sub_id_word", 64'(want.sub_id_word), 64'(got.sub_id_word));
      compare_field("main_id_word", 64'(want.main_id_word), 64'(got.main_id_word));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   idle_on;
  int   hold_left;

  dsg_in_if  in_chan();
  dsg_out_if out_chan();

  subcode_scoreboard sb = new();

  dat_subcode_timecode_generator #(.COUNT_BITS(24)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= $urandom_range(0, 8);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_frame(in_chan.restart_relative, in_chan.rate_code,
                      in_chan.track_no, in_chan.start_mark);
      if (out_chan.valid && out_chan.ready)
        sb.check_subcode({out_chan.relative_pack, out_chan.absolute_pack,
                          out_chan.sub_id_word, out_chan.main_id_word});
    end
  end

  task automatic send_frame(logic restart, logic [1:0] rate, logic [9:0] pno, logic smark);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.restart_relative <= restart;
    in_chan.rate_code        <= rate;
    in_chan.track_no         <= pno;
    in_chan.start_mark       <= smark;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_random(bit allow_restart);
    logic [9:0] pno;
    case ($urandom_range(0, 7))
      0:       pno = 10'd0;
      1:       pno = 10'($urandom_range(1000, 1023));
      default: pno = 10'($urandom_range(0, 1023));
    endcase
    send_frame(allow_restart && $urandom_range(0, 31) == 0, 2'($urandom_range(0, 3)), pno,
               1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_subcode.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_long_play(bit lp);
    cfg_we    <= 1'b1;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.long_play = lp;
  endtask

  initial begin
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_wdata                <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.restart_relative <= 1'b0;
    in_chan.rate_code        <= RATE_48K;
    in_chan.track_no         <= '0;
    in_chan.start_mark       <= 1'b0;
    idle_on                  = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_long_play(1'b0);
    send_frame(1'b0, RATE_48K,  10'd0,    1'b0);
    send_frame(1'b0, RATE_44K,  10'd1,    1'b1);
    send_frame(1'b0, RATE_32K,  10'd9,    1'b0);
    send_frame(1'b0, RATE_NONE, 10'd10,   1'b1);
    send_frame(1'b1, RATE_48K,  10'd99,   1'b0);
    send_frame(1'b0, RATE_44K,  10'd100,  1'b1);
    send_frame(1'b0, RATE_32K,  10'd999,  1'b0);
    send_frame(1'b0, RATE_NONE, 10'd1000, 1'b1);
    send_frame(1'b0, RATE_48K,  10'd1023, 1'b1);
    send_frame(1'b1, RATE_44K,  10'd512,  1'b0);
    send_frame(1'b1, RATE_32K,  10'd0,    1'b1);
    send_frame(1'b0, RATE_48K,  10'd0,    1'b1);
    send_frame(1'b0, RATE_44K,  10'd341,  1'b0);
    send_frame(1'b0, RATE_32K,  10'd682,  1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_long_play(ph % 2 == 0);
      for (int chunk = 0; chunk < 3; chunk++) begin
        idle_on = ($urandom_range(0, 3) != 0);
        repeat (40) send_random(1'b1);
      end
    end

    // closing stretch at full rate in both play modes
    idle_on = 1'b0;
    drain();
    set_long_play(1'b1);
    repeat (80) send_random(1'b0);
    drain();
    set_long_play(1'b0);
    repeat (90) send_random(1'b0);
    drain();

    if (sb.expected_subcode.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.expected_subcode.size()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
